@@ rtl/core/trss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trss_pkg
// Types, constants and the hash fold function of the Toeplitz queue selector.
// ----------------------------------------------------------------------------
package trss_pkg;

	localparam int unsigned TABLE_ENTRIES = 16;
	localparam int unsigned KEY_BYTES     = 40;
	localparam int unsigned ENTRY_BITS    = 4;
	localparam int unsigned HASH_BITS     = 32;
	localparam int unsigned SLOT_BITS     = $clog2(TABLE_ENTRIES);
	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 64;
	localparam int unsigned COUNT_BITS    = 5;

	// The longest hashed string is 12 bytes, so no window reaches past key bit
	// 126 and only the first two key words take part in any hash.
	localparam int unsigned USED_KEY_BITS = 128;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_KEY_WORD_0  = 3'd0,
		REG_KEY_WORD_1  = 3'd1,
		REG_KEY_WORD_2  = 3'd2,
		REG_KEY_WORD_3  = 3'd3,
		REG_KEY_WORD_4  = 3'd4,
		REG_QUEUE_TABLE = 3'd5,
		REG_QUEUE_COUNT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        is_ipv4;
		logic        is_tcp;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} req_t;

	typedef struct packed {
		logic [ENTRY_BITS-1:0] queue_index;
		logic [HASH_BITS-1:0]  hash_value;
		logic                  hash_valid;
	} res_t;

	typedef struct packed {
		logic [CFG_ADDR_BITS-1:0] addr;
		logic [CFG_DATA_BITS-1:0] wdata;
	} cfg_t;

	// XOR of the 32-bit key windows selected by the set bits of one 32-bit
	// slice of the hashed string. The slice starts at string bit offset.
	function automatic logic [HASH_BITS-1:0] toeplitz_fold(
		input logic [USED_KEY_BITS-1:0] key,
		input logic [31:0]              data,
		input int unsigned              offset
	);
		logic [HASH_BITS-1:0] acc;
		acc = '0;
		for (int unsigned b = 0; b < 32; b++) begin
			if (data[31-b])
				acc = acc ^ key[USED_KEY_BITS-1-(offset+b) -: HASH_BITS];
		end
		return acc;
	endfunction

	// Remainder of a 4-bit entry by the queue count, by restoring division over
	// three quotient bits; a count above the entry leaves it unchanged. Callers
	// exclude counts of zero and one, so the quotient always stays below eight.
	function automatic logic [ENTRY_BITS-1:0] entry_mod(
		input logic [ENTRY_BITS-1:0] entry,
		input logic [COUNT_BITS-1:0] count
	);
		logic [COUNT_BITS+1:0] r;
		logic [COUNT_BITS+1:0] d;
		r = (COUNT_BITS+2)'(entry);
		for (int unsigned s = 0; s < 3; s++) begin
			d = (COUNT_BITS+2)'(count) << (2 - s);
			if (r >= d)
				r = r - d;
		end
		return r[ENTRY_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/trss_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trss_if
// Valid/ready channels of the queue selector: header requests, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface trss_req_if import trss_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface trss_res_if import trss_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface trss_cfg_if import trss_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/toeplitz_rss_queue_select.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toeplitz_rss_queue_select
// Toeplitz hash over IPv4 header fields and transmit queue selection.
// ----------------------------------------------------------------------------
// Usage:
// A request on "in" carries the header fields of one packet. One result per
// request leaves on "out" in request order. The pipeline has four register
// stages: source address fold, destination address fold, port fold, then
// send table lookup and queue reduction. The last stage is the output
// register. One request is taken every cycle while the output register can move.
// When the receiver stalls, all stages hold and in.ready drops only while a
// result waits in the output register; nothing is lost or repeated.
// The "cfg" channel is always ready and writes at most one register per request;
// writes are expected only while no request is in flight.
// Reset empties the pipeline, clears the key and send table and sets the
// queue count to one. Key words two to four are accepted but never affect
// the hash, since the hashed string is at most twelve bytes long.
// ----------------------------------------------------------------------------
module toeplitz_rss_queue_select import trss_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	trss_req_if.sink      in,
	trss_res_if.source    out,
	trss_cfg_if.sink      cfg
);

	logic [63:0]              key0_q;
	logic [63:0]              key1_q;
	logic [63:0]              table_q;
	logic [COUNT_BITS-1:0]    count_q;
	logic [USED_KEY_BITS-1:0] key;

	assign key       = {key0_q, key1_q};
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q  <= '0;
			key1_q  <= '0;
			table_q <= '0;
			count_q <= COUNT_BITS'(1);
		end else if (cfg.valid) begin
			case (cfg.data.addr)
				REG_KEY_WORD_0:  key0_q  <= cfg.data.wdata;
				REG_KEY_WORD_1:  key1_q  <= cfg.data.wdata;
				REG_QUEUE_TABLE: table_q <= cfg.data.wdata;
				REG_QUEUE_COUNT: count_q <= cfg.data.wdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a result waits in the output stage.
	logic adv;
	assign adv      = !out.valid || out.ready;
	assign in.ready = adv;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 ipv4_s1, ipv4_s2, ipv4_s3;
	logic [31:0]          dst_s1;
	logic [31:0]          ports_s1, ports_s2;
	logic [HASH_BITS-1:0] hash_s1, hash_s2, hash_s3;
	res_t                 res_s4;

	logic [31:0] src_m;
	logic [31:0] dst_m;
	logic [31:0] ports_m;

	// Non-IPv4 packets hash an all-zero string, which yields a zero hash.
	assign src_m   = in.data.is_ipv4 ? in.data.src_addr : '0;
	assign dst_m   = in.data.is_ipv4 ? in.data.dst_addr : '0;
	assign ports_m = (in.data.is_ipv4 && in.data.is_tcp) ?
		{in.data.src_port, in.data.dst_port} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	logic [ENTRY_BITS-1:0] entry;
	logic [ENTRY_BITS-1:0] queue;

	assign entry = table_q[hash_s3[SLOT_BITS-1:0]*ENTRY_BITS +: ENTRY_BITS];
	assign queue = (ipv4_s3 && count_q > COUNT_BITS'(1)) ?
		entry_mod(entry, count_q) : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			ipv4_s1  <= in.data.is_ipv4;
			dst_s1   <= dst_m;
			ports_s1 <= ports_m;
			hash_s1  <= toeplitz_fold(key, src_m, 0);

			ipv4_s2  <= ipv4_s1;
			ports_s2 <= ports_s1;
			hash_s2  <= hash_s1 ^ toeplitz_fold(key, dst_s1, 32);

			ipv4_s3  <= ipv4_s2;
			hash_s3  <= hash_s2 ^ toeplitz_fold(key, ports_s2, 64);

			res_s4.queue_index <= queue;
			res_s4.hash_value  <= hash_s3;
			res_s4.hash_valid  <= ipv4_s3;
		end
	end

	assign out.valid = valid_s4;
	assign out.data  = res_s4;

endmodule
`default_nettype wire

@@ rtl/core/trss_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trss_checker
// Port-level checks of the queue selector, bound to the top level.
// ----------------------------------------------------------------------------
module trss_checker import trss_pkg::*; (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [ENTRY_BITS-1:0] out_queue,
	input wire [HASH_BITS-1:0]  out_hash,
	input wire                  out_hash_valid,
	input wire                  cfg_ready
);

	// A stalled result keeps its valid and payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_queue) &&
		$stable(out_hash) && $stable(out_hash_valid))
		else $error("stalled result changed");

	// An unhashed packet reports queue zero and a zero hash.
	a_unhashed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_hash_valid |-> out_queue == '0 && out_hash == '0)
		else $error("unhashed result is not zero");

	// Requests are taken whenever the output register can move.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("request refused while output free");

	// With the receiver ready and no request taken for as long as the pipeline is
	// deep, the pipeline has emptied and no result is shown.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && out_ready) [*4] |=> !out_valid)
		else $error("result without request");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind toeplitz_rss_queue_select trss_checker u_trss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in.valid),
	.in_ready       (in.ready),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.out_queue      (out.data.queue_index),
	.out_hash       (out.data.hash_value),
	.out_hash_valid (out.data.hash_valid),
	.cfg_ready      (cfg.ready)
);
`default_nettype wire
